FILE: rtl/pts_pkg.sv
package pts_pkg;

    localparam int MAX_TASKS_DEF = 16;
    localparam int TICK_BITS_DEF = 32;

    localparam logic [2:0] FN_MAKE_READY = 3'd0;
    localparam logic [2:0] FN_YIELD      = 3'd1;
    localparam logic [2:0] FN_SLEEP      = 3'd2;
    localparam logic [2:0] FN_SELECT     = 3'd3;
    localparam logic [2:0] FN_TICK       = 3'd4;

    typedef struct packed {
        logic [2:0]         func;
        logic [3:0]         task_id;
        logic signed [7:0]  priority_req;
        logic [15:0]        sleep_ticks;
    } t_cmd;

    typedef struct packed {
        logic [3:0] selected_task;
        logic       selected_valid;
        logic       selected_timed_out;
        logic [4:0] woken_count;
        logic       switch_request;
    } t_res;

    typedef struct packed {
        logic              vld;
        logic [3:0]        id;
        logic signed [7:0] prio;
    } t_ent;

    typedef struct packed {
        logic ins;
        logic pop;
    } t_qctl;

endpackage

FILE: rtl/pts_ready_cell.sv
module pts_ready_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pts_pkg::t_qctl i_ctl,
    input  pts_pkg::t_ent  i_new,
    input  pts_pkg::t_ent  i_prev,
    input  logic           i_prev_stay,
    input  pts_pkg::t_ent  i_next,
    output pts_pkg::t_ent  o_ent,
    output logic           o_stay
);
    import pts_pkg::*;

    t_ent r_ent;
    t_ent n_ent;

    assign o_stay = r_ent.vld && (r_ent.prio >= i_new.prio);
    assign o_ent  = r_ent;

    always_comb begin
        n_ent = r_ent;
        if (i_ctl.pop) begin
            n_ent = i_next;
        end else if (i_ctl.ins && !o_stay) begin
            n_ent = i_prev_stay ? i_new : i_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
        if (!i_rst_n) begin
            r_ent.vld <= 1'b0;
        end
    end

endmodule

FILE: rtl/pts_sleep_cell.sv
module pts_sleep_cell #(
    parameter int TICK_BITS = pts_pkg::TICK_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pts_pkg::t_qctl       i_ctl,
    input  logic [TICK_BITS-1:0] i_tick,
    input  logic [TICK_BITS-1:0] i_dist,
    input  pts_pkg::t_ent        i_new,
    input  logic [TICK_BITS-1:0] i_new_wake,
    input  pts_pkg::t_ent        i_prev,
    input  logic [TICK_BITS-1:0] i_prev_wake,
    input  logic                 i_prev_stay,
    input  pts_pkg::t_ent        i_next,
    input  logic [TICK_BITS-1:0] i_next_wake,
    output pts_pkg::t_ent        o_ent,
    output logic [TICK_BITS-1:0] o_wake,
    output logic                 o_stay
);
    import pts_pkg::*;

    t_ent                 r_ent;
    t_ent                 n_ent;
    logic [TICK_BITS-1:0] r_wake;
    logic [TICK_BITS-1:0] n_wake;
    logic [TICK_BITS-1:0] wake_dist;

    assign wake_dist = r_wake - i_tick;
    assign o_stay    = r_ent.vld && (wake_dist <= i_dist);
    assign o_ent     = r_ent;
    assign o_wake    = r_wake;

    always_comb begin
        n_ent  = r_ent;
        n_wake = r_wake;
        if (i_ctl.pop) begin
            n_ent  = i_next;
            n_wake = i_next_wake;
        end else if (i_ctl.ins && !o_stay) begin
            n_ent  = i_prev_stay ? i_new : i_prev;
            n_wake = i_prev_stay ? i_new_wake : i_prev_wake;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent  <= n_ent;
        r_wake <= n_wake;
        if (!i_rst_n) begin
            r_ent.vld <= 1'b0;
        end
    end

endmodule

FILE: rtl/priority_task_scheduler_with_sleep.sv
// Channel   Ports                  Handshake
// command   i_cmd                  taken when start is high and busy is low
// result    o_res                  one beat per command, marked by o_strobe
//
// Every command but tick gives its result on the cycle after it is taken.
// A tick starts a wake sweep: one cell-chain insert per woken sleeper,
// then the current task is requeued.
// Reset clears both chains, the timeout marks, the tick counter and the
// current task. The receiver cannot stall; busy is high only during a tick.
module priority_task_scheduler_with_sleep #(
    parameter int MAX_TASKS = pts_pkg::MAX_TASKS_DEF,
    parameter int TICK_BITS = pts_pkg::TICK_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  pts_pkg::t_cmd i_cmd,
    output logic          busy,
    output logic          o_strobe,
    output pts_pkg::t_res o_res
);
    import pts_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_WAKE = 1'b1;

    logic                 r_state;
    logic                 n_state;
    logic [TICK_BITS-1:0] r_tick;
    logic [TICK_BITS-1:0] n_tick;
    t_ent                 r_cur;
    t_ent                 n_cur;
    logic [15:0]          r_to;
    logic [15:0]          n_to;
    logic [4:0]           r_woken;
    logic [4:0]           n_woken;
    logic                 r_strobe;
    logic                 n_strobe;
    t_res                 r_res;
    t_res                 n_res;

    t_qctl                rq_ctl;
    t_ent                 rq_new;
    t_qctl                sq_ctl;
    t_ent                 sq_new;
    logic [TICK_BITS-1:0] sq_dist;
    logic [TICK_BITS-1:0] sq_wake_new;

    t_ent                 r_ent  [MAX_TASKS];
    logic                 r_stay [MAX_TASKS];
    t_ent                 s_ent  [MAX_TASKS];
    logic [TICK_BITS-1:0] s_wake [MAX_TASKS];
    logic                 s_stay [MAX_TASKS];

    logic                 acc;
    logic                 held;
    logic                 rfull;
    logic                 sfull;
    logic                 wake_now;

    localparam t_ent NULL_ENT = '{vld: 1'b0, id: 4'd0, prio: 8'sd0};

    for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cells
        pts_ready_cell u_rc (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (rq_ctl),
            .i_new       (rq_new),
            .i_prev      ((g == 0) ? NULL_ENT : r_ent[(g == 0) ? 0 : g - 1]),
            .i_prev_stay ((g == 0) ? 1'b1 : r_stay[(g == 0) ? 0 : g - 1]),
            .i_next      ((g == MAX_TASKS - 1) ? NULL_ENT
                          : r_ent[(g == MAX_TASKS - 1) ? g : g + 1]),
            .o_ent       (r_ent[g]),
            .o_stay      (r_stay[g])
        );
        pts_sleep_cell #(.TICK_BITS(TICK_BITS)) u_sc (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (sq_ctl),
            .i_tick      (r_tick),
            .i_dist      (sq_dist),
            .i_new       (sq_new),
            .i_new_wake  (sq_wake_new),
            .i_prev      ((g == 0) ? NULL_ENT : s_ent[(g == 0) ? 0 : g - 1]),
            .i_prev_wake (s_wake[(g == 0) ? 0 : g - 1]),
            .i_prev_stay ((g == 0) ? 1'b1 : s_stay[(g == 0) ? 0 : g - 1]),
            .i_next      ((g == MAX_TASKS - 1) ? NULL_ENT
                          : s_ent[(g == MAX_TASKS - 1) ? g : g + 1]),
            .i_next_wake (s_wake[(g == MAX_TASKS - 1) ? g : g + 1]),
            .o_ent       (s_ent[g]),
            .o_wake      (s_wake[g]),
            .o_stay      (s_stay[g])
        );
    end

    assign busy     = (r_state == S_WAKE);
    assign acc      = start && !busy;
    assign rfull    = r_ent[MAX_TASKS-1].vld;
    assign sfull    = s_ent[MAX_TASKS-1].vld;
    assign wake_now = s_ent[0].vld && (s_wake[0] == r_tick);
    assign sq_dist  = (i_cmd.sleep_ticks == 16'd0) ? TICK_BITS'(1)
                                                   : TICK_BITS'(i_cmd.sleep_ticks);
    assign sq_wake_new = r_tick + sq_dist;

    always_comb begin
        held = r_cur.vld && (r_cur.id == i_cmd.task_id);
        for (int k = 0; k < MAX_TASKS; k++) begin
            held = held || (r_ent[k].vld && (r_ent[k].id == i_cmd.task_id))
                        || (s_ent[k].vld && (s_ent[k].id == i_cmd.task_id));
        end
    end

    always_comb begin
        n_state  = r_state;
        n_tick   = r_tick;
        n_cur    = r_cur;
        n_to     = r_to;
        n_woken  = r_woken;
        n_strobe = 1'b0;
        n_res    = '0;
        rq_ctl   = '0;
        rq_new   = r_cur;
        sq_ctl   = '0;
        sq_new   = r_cur;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_strobe = 1'b1;
                    unique case (i_cmd.func)
                        FN_MAKE_READY: begin
                            rq_new = '{vld: 1'b1, id: i_cmd.task_id,
                                       prio: i_cmd.priority_req};
                            rq_ctl.ins = !held && !rfull
                                         && (32'(i_cmd.task_id) < 32'(MAX_TASKS));
                        end
                        FN_YIELD: begin
                            if (r_cur.vld) begin
                                rq_ctl.ins = !rfull;
                                n_cur.vld  = 1'b0;
                                n_res.switch_request = 1'b1;
                            end
                        end
                        FN_SLEEP: begin
                            if (r_cur.vld) begin
                                if (!sfull) begin
                                    sq_ctl.ins     = 1'b1;
                                    n_to[r_cur.id] = 1'b0;
                                end
                                n_cur.vld = 1'b0;
                                n_res.switch_request = 1'b1;
                            end
                        end
                        FN_SELECT: begin
                            if (r_ent[0].vld) begin
                                rq_ctl.pop = 1'b1;
                                n_cur      = r_ent[0];
                                n_res.selected_task      = r_ent[0].id;
                                n_res.selected_valid     = 1'b1;
                                n_res.selected_timed_out = r_to[r_ent[0].id];
                            end else begin
                                n_cur.vld = 1'b0;
                            end
                        end
                        FN_TICK: begin
                            n_strobe = 1'b0;
                            n_tick   = r_tick + TICK_BITS'(1);
                            n_woken  = '0;
                            n_state  = S_WAKE;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_WAKE: begin
                if (wake_now) begin
                    sq_ctl.pop      = 1'b1;
                    rq_new          = s_ent[0];
                    rq_ctl.ins      = !rfull;
                    n_to[s_ent[0].id] = 1'b1;
                    if (r_woken != 5'd31) begin
                        n_woken = r_woken + 5'd1;
                    end
                end else begin
                    if (r_cur.vld) begin
                        rq_ctl.ins = !rfull;
                        n_cur.vld  = 1'b0;
                    end
                    n_strobe             = 1'b1;
                    n_res.woken_count    = r_woken;
                    n_res.switch_request = 1'b1;
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cur.id   <= n_cur.id;
        r_cur.prio <= n_cur.prio;
        r_woken    <= n_woken;
        r_res      <= n_res;
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_tick    <= '0;
            r_cur.vld <= 1'b0;
            r_to      <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_tick    <= n_tick;
            r_cur.vld <= n_cur.vld;
            r_to      <= n_to;
            r_strobe  <= n_strobe;
        end
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

    a_cmd_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd.func != FN_TICK) |=> o_strobe)
        else $error("missing result beat");

    a_wake_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAKE) |-> !o_strobe)
        else $error("result beat during wake sweep");

    a_sel_no_switch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !(o_res.selected_valid && o_res.switch_request))
        else $error("select and switch together");

    a_ready_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ent[0].vld && r_ent[1].vld) |-> (r_ent[0].prio >= r_ent[1].prio))
        else $error("ready head out of order");

endmodule

FILE: dv/priority_task_scheduler_with_sleep_tb.sv
`timescale 1ns / 100ps

module priority_task_scheduler_with_sleep_tb;
    import pts_pkg::*;

    localparam int NTASK = 16;
    localparam int N_RANDOM = 1650;

    logic i_clk;
    logic i_rst_n;
    logic start;
    t_cmd i_cmd;
    logic busy;
    logic o_strobe;
    t_res o_res;

    priority_task_scheduler_with_sleep u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

    // scheduler mirror
    logic [3:0]        rdy_q [NTASK];
    int                rdy_n;
    logic [3:0]        slp_q [NTASK];
    int                slp_n;
    logic signed [7:0] prio_tbl [NTASK];
    logic [31:0]       wake_tbl [NTASK];
    logic              to_mark [NTASK];
    logic [31:0]       now_tick;
    logic [3:0]        cur_id;
    logic              cur_vld;

    t_cmd cmd_q[$];
    t_res sched_exp_q[$];
    int   n_issued;
    int   n_taken;
    int   gap_left;
    int   n_err;

    initial begin
        i_clk = 1'b0;
    end
    always #5 i_clk = ~i_clk;

    function automatic bit task_held(logic [3:0] id);
        if (cur_vld && cur_id == id) return 1'b1;
        for (int i = 0; i < rdy_n; i++) if (rdy_q[i] == id) return 1'b1;
        for (int i = 0; i < slp_n; i++) if (slp_q[i] == id) return 1'b1;
        return 1'b0;
    endfunction

    function automatic void ready_push(logic [3:0] id);
        int pos;
        pos = rdy_n;
        if (rdy_n >= NTASK) return;
        for (int i = 0; i < rdy_n; i++) begin
            if (prio_tbl[id] > prio_tbl[rdy_q[i]]) begin
                pos = i;
                break;
            end
        end
        for (int i = rdy_n; i > pos; i--) rdy_q[i] = rdy_q[i-1];
        rdy_q[pos] = id;
        rdy_n++;
    endfunction

    function automatic void sleep_push(logic [3:0] id, logic [15:0] ticks);
        int pos;
        logic [31:0] d;
        pos = slp_n;
        if (slp_n >= NTASK) return;
        d = (ticks == 0) ? 32'd1 : {16'd0, ticks};
        wake_tbl[id] = now_tick + d;
        to_mark[id] = 1'b0;
        for (int i = 0; i < slp_n; i++) begin
            if (wake_tbl[slp_q[i]] - now_tick > d) begin
                pos = i;
                break;
            end
        end
        for (int i = slp_n; i > pos; i--) slp_q[i] = slp_q[i-1];
        slp_q[pos] = id;
        slp_n++;
    endfunction

    function automatic t_res schedule_step(t_cmd c);
        t_res r;
        logic [3:0] w;
        r = '0;
        case (c.func)
            FN_MAKE_READY: begin
                if (!task_held(c.task_id)) begin
                    prio_tbl[c.task_id] = c.priority_req;
                    ready_push(c.task_id);
                end
            end
            FN_YIELD: begin
                if (cur_vld) begin
                    ready_push(cur_id);
                    cur_vld = 1'b0;
                    r.switch_request = 1'b1;
                end
            end
            FN_SLEEP: begin
                if (cur_vld) begin
                    sleep_push(cur_id, c.sleep_ticks);
                    cur_vld = 1'b0;
                    r.switch_request = 1'b1;
                end
            end
            FN_SELECT: begin
                if (rdy_n > 0) begin
                    cur_id = rdy_q[0];
                    for (int i = 0; i < rdy_n - 1; i++) rdy_q[i] = rdy_q[i+1];
                    rdy_n--;
                    cur_vld = 1'b1;
                    r.selected_task = cur_id;
                    r.selected_valid = 1'b1;
                    r.selected_timed_out = to_mark[cur_id];
                end else begin
                    cur_vld = 1'b0;
                end
            end
            FN_TICK: begin
                now_tick = now_tick + 1;
                while (slp_n > 0 && wake_tbl[slp_q[0]] == now_tick) begin
                    w = slp_q[0];
                    for (int i = 0; i < slp_n - 1; i++) slp_q[i] = slp_q[i+1];
                    slp_n--;
                    to_mark[w] = 1'b1;
                    ready_push(w);
                    if (r.woken_count < 5'd31) r.woken_count++;
                end
                if (cur_vld) begin
                    ready_push(cur_id);
                    cur_vld = 1'b0;
                end
                r.switch_request = 1'b1;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic t_cmd mk_cmd(logic [2:0] f, logic [3:0] id, logic [7:0] p,
                                    logic [15:0] t);
        t_cmd c;
        c.func = f;
        c.task_id = id;
        c.priority_req = p;
        c.sleep_ticks = t;
        return c;
    endfunction

    function automatic int pick_gap();
        int r;
        if ((n_issued / 150) % 3 == 1) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            n_err++;
        end
    endtask

    // drive beats
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && n_taken != n_issued) begin
            start <= 1'b1;
        end else if (gap_left > 0) begin
            start <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (cmd_q.size() > 0) begin
            i_cmd <= cmd_q.pop_front();
            start <= 1'b1;
            n_issued <= n_issued + 1;
            gap_left <= pick_gap();
        end else begin
            start <= 1'b0;
        end
    end

    // sample results, then predict from the accepted beat
    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n) begin
            if (o_strobe) begin
                if (sched_exp_q.size() == 0) begin
                    $error("result beat with nothing expected");
                    n_err++;
                end else begin
                    e = sched_exp_q.pop_front();
                    check_field("selected_task", e.selected_task, o_res.selected_task);
                    check_field("selected_valid", e.selected_valid, o_res.selected_valid);
                    check_field("selected_timed_out", e.selected_timed_out,
                                o_res.selected_timed_out);
                    check_field("woken_count", e.woken_count, o_res.woken_count);
                    check_field("switch_request", e.switch_request, o_res.switch_request);
                end
            end
            if (start && !busy) begin
                sched_exp_q.push_back(schedule_step(i_cmd));
                n_taken <= n_taken + 1;
            end
        end
    end

    initial begin
        int r;
        t_cmd c;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cmd = '0;
        n_issued = 0;
        n_taken = 0;
        gap_left = 0;
        n_err = 0;
        rdy_n = 0;
        slp_n = 0;
        now_tick = '0;
        cur_id = '0;
        cur_vld = 1'b0;
        for (int i = 0; i < NTASK; i++) begin
            prio_tbl[i] = '0;
            wake_tbl[i] = '0;
            to_mark[i] = 1'b0;
        end

        cmd_q.push_back(mk_cmd(FN_SELECT, 4'd0, 8'd0, 16'd0));
        cmd_q.push_back(mk_cmd(FN_YIELD, 4'd0, 8'd0, 16'd0));
        cmd_q.push_back(mk_cmd(FN_SLEEP, 4'd0, 8'd0, 16'd5));
        cmd_q.push_back(mk_cmd(FN_TICK, 4'd0, 8'd0, 16'd0));
        cmd_q.push_back(mk_cmd(FN_MAKE_READY, 4'd0, 8'h80, 16'd0));
        cmd_q.push_back(mk_cmd(FN_MAKE_READY, 4'd15, 8'h7f, 16'hffff));
        cmd_q.push_back(mk_cmd(FN_MAKE_READY, 4'd5, 8'h00, 16'd0));
        cmd_q.push_back(mk_cmd(FN_MAKE_READY, 4'd6, 8'h00, 16'd0));
        cmd_q.push_back(mk_cmd(FN_MAKE_READY, 4'd15, 8'h80, 16'd0));
        cmd_q.push_back(mk_cmd(FN_SELECT, 4'd0, 8'd0, 16'd0));
        cmd_q.push_back(mk_cmd(FN_MAKE_READY, 4'd15, 8'h10, 16'd0));
        cmd_q.push_back(mk_cmd(FN_SLEEP, 4'd0, 8'd0, 16'd0));
        cmd_q.push_back(mk_cmd(FN_SELECT, 4'd0, 8'd0, 16'd0));
        cmd_q.push_back(mk_cmd(FN_SLEEP, 4'd0, 8'd0, 16'd1));
        cmd_q.push_back(mk_cmd(FN_SELECT, 4'd0, 8'd0, 16'd0));
        cmd_q.push_back(mk_cmd(FN_SELECT, 4'd0, 8'd0, 16'd0));
        cmd_q.push_back(mk_cmd(FN_TICK, 4'd0, 8'd0, 16'd0));
        cmd_q.push_back(mk_cmd(FN_TICK, 4'd0, 8'd0, 16'd0));
        cmd_q.push_back(mk_cmd(FN_SELECT, 4'd0, 8'd0, 16'd0));
        cmd_q.push_back(mk_cmd(FN_SLEEP, 4'd0, 8'd0, 16'hffff));
        cmd_q.push_back(mk_cmd(3'd5, 4'd9, 8'h55, 16'haaaa));
        cmd_q.push_back(mk_cmd(3'd6, 4'd3, 8'h33, 16'h5555));
        cmd_q.push_back(mk_cmd(3'd7, 4'd7, 8'hff, 16'hffff));
        cmd_q.push_back(mk_cmd(FN_SELECT, 4'd0, 8'd0, 16'd0));
        cmd_q.push_back(mk_cmd(FN_YIELD, 4'd0, 8'd0, 16'd0));

        for (int k = 0; k < N_RANDOM; k++) begin
            c = $urandom;
            r = $urandom_range(0, 99);
            if (r < 28) c.func = FN_MAKE_READY;
            else if (r < 48) c.func = FN_SELECT;
            else if (r < 58) c.func = FN_YIELD;
            else if (r < 73) c.func = FN_SLEEP;
            else if (r < 95) c.func = FN_TICK;
            else c.func = 3'($urandom_range(5, 7));
            r = $urandom_range(0, 99);
            if (r < 70) c.sleep_ticks = 16'($urandom_range(0, 6));
            else if (r < 90) c.sleep_ticks = 16'($urandom_range(0, 40));
            cmd_q.push_back(c);
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (cmd_q.size() > 0 || n_taken != n_issued || start ||
               sched_exp_q.size() > 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (n_err == 0 && sched_exp_q.size() == 0)
            $display("priority_task_scheduler_with_sleep regression: pass");
        else
            $display("priority_task_scheduler_with_sleep regression: fail");
        $finish;
    end

    initial begin
        #5ms;
        $display("priority_task_scheduler_with_sleep regression: fail");
        $finish;
    end

endmodule

FILE: files.f
rtl/pts_pkg.sv
rtl/pts_ready_cell.sv
rtl/pts_sleep_cell.sv
rtl/priority_task_scheduler_with_sleep.sv
dv/priority_task_scheduler_with_sleep_tb.sv
